// ===== rtl/core/jbt_pkg.sv =====
package jbt_pkg;

    // lexer modes
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_STR  = 3'd1;
    localparam logic [2:0] MODE_ESC  = 3'd2;
    localparam logic [2:0] MODE_NUM  = 3'd3;
    localparam logic [2:0] MODE_SKIP = 3'd4;

    // token kinds
    localparam logic [3:0] KIND_NULL   = 4'd0;
    localparam logic [3:0] KIND_NUMBER = 4'd1;
    localparam logic [3:0] KIND_STRING = 4'd2;
    localparam logic [3:0] KIND_TRUE   = 4'd3;
    localparam logic [3:0] KIND_FALSE  = 4'd4;
    localparam logic [3:0] KIND_LBRACK = 4'd5;
    localparam logic [3:0] KIND_RBRACK = 4'd6;
    localparam logic [3:0] KIND_LBRACE = 4'd7;
    localparam logic [3:0] KIND_RBRACE = 4'd8;
    localparam logic [3:0] KIND_COMMA  = 4'd9;
    localparam logic [3:0] KIND_COLON  = 4'd10;

    // characters of interest
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;

    // keyword letters left after the first one
    localparam logic [2:0] SKIP_TRUE  = 3'd3;
    localparam logic [2:0] SKIP_FALSE = 3'd4;
    localparam logic [2:0] SKIP_NULL  = 3'd3;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // result queue sizing
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [7:0]  lexeme_byte;
        logic        byte_valid;
        logic        token_start;
        logic        token_end;
        logic        lex_error;
        logic [15:0] tokens_seen;
        logic        last_of_run;
    } token_rec_t;

    // build one token record, content byte forced to zero when not valid
    function automatic token_rec_t mk_rec(
        input logic [3:0]  kind,
        input logic [7:0]  lexeme,
        input logic        bvalid,
        input logic        start,
        input logic        stop,
        input logic        err,
        input logic [15:0] seen
    );
        token_rec_t r;
        r.token_kind  = kind;
        r.lexeme_byte = bvalid ? lexeme : 8'h00;
        r.byte_valid  = bvalid;
        r.token_start = start;
        r.token_end   = stop;
        r.lex_error   = err;
        r.tokens_seen = seen;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/core/json_byte_tokenizer_top.sv =====
// a byte is held in the input register, lexed into the result queue once the queue
//   has room for two records, and its first record is offered from the queue head
// throughput: one byte per cycle while the queue has room for two records; a byte
//   that gives two records (a closed number or a kept backslash) pushes both at once
// the 4-entry result queue must have room for two records before a byte is lexed
// reset (rst_n low, asynchronous): lexer idle, token count and error cleared,
//   input register and result queue empty
module json_byte_tokenizer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [7:0]  lexeme_byte,
    output logic        byte_valid,
    output logic        token_start,
    output logic        token_end,
    output logic        lex_error,
    output logic [15:0] tokens_seen,
    output logic        last_of_run
);

    logic [7:0]          byte_reg;
    logic                full_reg;
    logic                step;
    logic                room_two;
    logic [1:0]          lex_cnt;
    logic [1:0]          push_cnt;
    jbt_pkg::token_rec_t rec0;
    jbt_pkg::token_rec_t rec1;
    jbt_pkg::token_rec_t head;

    // lex the held byte when the queue can take both possible records
    assign step     = full_reg && room_two;
    assign in_ready = !full_reg || step;
    assign push_cnt = step ? lex_cnt : 2'd0;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

    jbt_lexer u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (byte_reg),
        .rec_cnt (lex_cnt),
        .rec0    (rec0),
        .rec1    (rec1)
    );

    jbt_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (rec0),
        .push1     (rec1),
        .room_two  (room_two),
        .pop_valid (out_valid),
        .pop_ready (out_ready),
        .pop_rec   (head)
    );

    // result fields
    assign token_kind  = head.token_kind;
    assign lexeme_byte = head.lexeme_byte;
    assign byte_valid  = head.byte_valid;
    assign token_start = head.token_start;
    assign token_end   = head.token_end;
    assign lex_error   = head.lex_error;
    assign tokens_seen = head.tokens_seen;
    assign last_of_run = head.last_of_run;

endmodule

// ===== rtl/core/jbt_lexer.sv =====
module jbt_lexer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             byte_in,
    output logic [1:0]             rec_cnt,
    output jbt_pkg::token_rec_t    rec0,
    output jbt_pkg::token_rec_t    rec1
);

    logic [2:0]  mode_reg, mode_next;
    logic [2:0]  skip_reg, skip_next;
    logic [15:0] count_reg, count_next;
    logic        err_reg, err_next;

    logic [15:0] count_sat;
    logic        is_digit;

    // idle path results
    logic                idle_has;
    jbt_pkg::token_rec_t idle_rec;
    logic [2:0]          idle_mode;
    logic [2:0]          idle_skip;
    logic [15:0]         idle_cnt;
    logic                idle_err;

    // string path results
    logic                str_has;
    jbt_pkg::token_rec_t str_rec;
    logic [2:0]          str_mode;
    logic                str_err;

    assign count_sat = (count_reg == jbt_pkg::COUNT_MAX) ? count_reg : count_reg + 16'd1;
    assign is_digit  = (byte_in >= jbt_pkg::CH_ZERO) && (byte_in <= jbt_pkg::CH_NINE);

    // byte between tokens
    always_comb
    begin
        idle_has  = 1'b0;
        idle_rec  = '0;
        idle_mode = jbt_pkg::MODE_IDLE;
        idle_skip = skip_reg;
        idle_cnt  = count_reg;
        idle_err  = err_reg;
        if (byte_in == jbt_pkg::CH_NUL || byte_in == jbt_pkg::CH_SPACE ||
            (byte_in >= jbt_pkg::CH_TAB && byte_in <= jbt_pkg::CH_CR))
        begin
            idle_has = 1'b0;
        end
        else if (byte_in == jbt_pkg::CH_QUOTE)
        begin
            idle_has  = 1'b1;
            idle_cnt  = count_sat;
            idle_mode = jbt_pkg::MODE_STR;
            idle_rec  = jbt_pkg::mk_rec(jbt_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0,
                                        err_reg, count_sat);
        end
        else if (is_digit || byte_in == jbt_pkg::CH_MINUS)
        begin
            idle_has  = 1'b1;
            idle_cnt  = count_sat;
            idle_mode = jbt_pkg::MODE_NUM;
            idle_rec  = jbt_pkg::mk_rec(jbt_pkg::KIND_NUMBER, byte_in, 1'b1, 1'b1, 1'b0,
                                        err_reg, count_sat);
        end
        else
        begin
            idle_has = 1'b1;
            idle_cnt = count_sat;
            idle_rec = jbt_pkg::mk_rec(jbt_pkg::KIND_NULL, 8'h00, 1'b0, 1'b1, 1'b1,
                                       err_reg, count_sat);
            case (byte_in)
                jbt_pkg::CH_T:
                begin
                    idle_rec.token_kind = jbt_pkg::KIND_TRUE;
                    idle_skip = jbt_pkg::SKIP_TRUE;
                    idle_mode = jbt_pkg::MODE_SKIP;
                end
                jbt_pkg::CH_F:
                begin
                    idle_rec.token_kind = jbt_pkg::KIND_FALSE;
                    idle_skip = jbt_pkg::SKIP_FALSE;
                    idle_mode = jbt_pkg::MODE_SKIP;
                end
                jbt_pkg::CH_N:
                begin
                    idle_rec.token_kind = jbt_pkg::KIND_NULL;
                    idle_skip = jbt_pkg::SKIP_NULL;
                    idle_mode = jbt_pkg::MODE_SKIP;
                end
                jbt_pkg::CH_LBRACK: idle_rec.token_kind = jbt_pkg::KIND_LBRACK;
                jbt_pkg::CH_RBRACK: idle_rec.token_kind = jbt_pkg::KIND_RBRACK;
                jbt_pkg::CH_LBRACE: idle_rec.token_kind = jbt_pkg::KIND_LBRACE;
                jbt_pkg::CH_RBRACE: idle_rec.token_kind = jbt_pkg::KIND_RBRACE;
                jbt_pkg::CH_COMMA:  idle_rec.token_kind = jbt_pkg::KIND_COMMA;
                jbt_pkg::CH_COLON:  idle_rec.token_kind = jbt_pkg::KIND_COLON;
                default:
                begin
                    // unknown byte: dropped, sticky error
                    idle_has = 1'b0;
                    idle_cnt = count_reg;
                    idle_err = 1'b1;
                end
            endcase
        end
    end

    // byte inside a string
    always_comb
    begin
        str_has  = 1'b1;
        str_mode = jbt_pkg::MODE_STR;
        str_err  = err_reg;
        str_rec  = jbt_pkg::mk_rec(jbt_pkg::KIND_STRING, byte_in, 1'b1, 1'b0, 1'b0,
                                   err_reg, count_reg);
        if (byte_in == jbt_pkg::CH_QUOTE)
        begin
            str_mode = jbt_pkg::MODE_IDLE;
            str_rec  = jbt_pkg::mk_rec(jbt_pkg::KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1,
                                       err_reg, count_reg);
        end
        else if (byte_in == jbt_pkg::CH_NUL)
        begin
            // unterminated string: flag, then close it
            str_mode = jbt_pkg::MODE_IDLE;
            str_err  = 1'b1;
            str_rec  = jbt_pkg::mk_rec(jbt_pkg::KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1,
                                       1'b1, count_reg);
        end
        else if (byte_in == jbt_pkg::CH_BSLASH)
        begin
            str_has  = 1'b0;
            str_mode = jbt_pkg::MODE_ESC;
        end
    end

    // mode dispatch and record placement
    always_comb
    begin
        rec_cnt    = 2'd0;
        rec0       = '0;
        rec1       = '0;
        mode_next  = mode_reg;
        skip_next  = skip_reg;
        count_next = count_reg;
        err_next   = err_reg;
        case (mode_reg)
            jbt_pkg::MODE_STR:
            begin
                rec0      = str_rec;
                rec_cnt   = {1'b0, str_has};
                mode_next = str_mode;
                err_next  = str_err;
            end
            jbt_pkg::MODE_ESC:
            begin
                if (byte_in == jbt_pkg::CH_BSLASH || byte_in == jbt_pkg::CH_QUOTE)
                begin
                    rec0      = jbt_pkg::mk_rec(jbt_pkg::KIND_STRING, byte_in, 1'b1, 1'b0,
                                                1'b0, err_reg, count_reg);
                    rec_cnt   = 2'd1;
                    mode_next = jbt_pkg::MODE_STR;
                end
                else
                begin
                    // pending backslash is content, then the byte as usual
                    rec0      = jbt_pkg::mk_rec(jbt_pkg::KIND_STRING, jbt_pkg::CH_BSLASH,
                                                1'b1, 1'b0, 1'b0, err_reg, count_reg);
                    rec1      = str_rec;
                    rec_cnt   = str_has ? 2'd2 : 2'd1;
                    mode_next = str_mode;
                    err_next  = str_err;
                end
            end
            jbt_pkg::MODE_NUM:
            begin
                if (is_digit || byte_in == jbt_pkg::CH_DOT)
                begin
                    rec0    = jbt_pkg::mk_rec(jbt_pkg::KIND_NUMBER, byte_in, 1'b1, 1'b0,
                                              1'b0, err_reg, count_reg);
                    rec_cnt = 2'd1;
                end
                else
                begin
                    // close the number, then treat the byte as between tokens
                    rec0       = jbt_pkg::mk_rec(jbt_pkg::KIND_NUMBER, 8'h00, 1'b0, 1'b0,
                                                 1'b1, err_reg, count_reg);
                    rec1       = idle_rec;
                    rec_cnt    = idle_has ? 2'd2 : 2'd1;
                    mode_next  = idle_mode;
                    skip_next  = idle_skip;
                    count_next = idle_cnt;
                    err_next   = idle_err;
                end
            end
            jbt_pkg::MODE_SKIP:
            begin
                if (byte_in == jbt_pkg::CH_NUL || skip_reg <= 3'd1)
                begin
                    skip_next = 3'd0;
                    mode_next = jbt_pkg::MODE_IDLE;
                end
                else
                begin
                    skip_next = skip_reg - 3'd1;
                end
            end
            default:
            begin
                rec0       = idle_rec;
                rec_cnt    = {1'b0, idle_has};
                mode_next  = idle_mode;
                skip_next  = idle_skip;
                count_next = idle_cnt;
                err_next   = idle_err;
            end
        endcase
        // mark the final record of this byte
        if (rec_cnt == 2'd2)
        begin
            rec1.last_of_run = 1'b1;
        end
        else
        begin
            rec0.last_of_run = 1'b1;
        end
    end

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= jbt_pkg::MODE_IDLE;
            skip_reg  <= 3'd0;
            count_reg <= 16'd0;
            err_reg   <= 1'b0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            skip_reg  <= skip_next;
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== rtl/core/jbt_out_fifo.sv =====
module jbt_out_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             push_cnt,
    input  jbt_pkg::token_rec_t    push0,
    input  jbt_pkg::token_rec_t    push1,
    output logic                   room_two,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output jbt_pkg::token_rec_t    pop_rec
);

    jbt_pkg::token_rec_t                entry_reg [jbt_pkg::FIFO_DEPTH];
    logic [jbt_pkg::FIFO_PTR_W-1:0]     wptr_reg, wptr_next;
    logic [jbt_pkg::FIFO_PTR_W-1:0]     rptr_reg, rptr_next;
    logic [jbt_pkg::FIFO_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [jbt_pkg::FIFO_PTR_W-1:0]     wptr_plus1;
    logic                               pop;

    assign pop        = pop_valid && pop_ready;
    assign pop_valid  = (cnt_reg != '0);
    assign pop_rec    = entry_reg[rptr_reg];
    assign room_two   = (cnt_reg <= jbt_pkg::FIFO_CNT_W'(jbt_pkg::FIFO_DEPTH - 2));
    assign wptr_plus1 = wptr_reg + 1'b1;

    // pointer and fill level update
    always_comb
    begin
        wptr_next = wptr_reg + push_cnt[jbt_pkg::FIFO_PTR_W-1:0];
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + jbt_pkg::FIFO_CNT_W'(push_cnt)
                    - jbt_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // record storage, up to two writes per cycle
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entry_reg[wptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            entry_reg[wptr_plus1] <= push1;
        end
    end

endmodule
